/* rtl/pis_pkg.sv */
// ----------------------------------------------------------------------------
// Process interlock sequencer package
// Shared word types, command and state codes, and the lookup functions for
// the transition graph and the per-state permission masks.
// ----------------------------------------------------------------------------
package pis_pkg;

   // Command codes carried in req_type.
   localparam logic [2:0] REQ_SELECT_MAT  = 3'd0;
   localparam logic [2:0] REQ_CHANGE_MAT  = 3'd1;
   localparam logic [2:0] REQ_ACK_STEP    = 3'd2;
   localparam logic [2:0] REQ_SET_STATE   = 3'd3;
   localparam logic [2:0] REQ_FAULT       = 3'd4;
   localparam logic [2:0] REQ_CLEAR_FAULT = 3'd5;

   // Machine state codes.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SHRED   = 3'd1;
   localparam logic [2:0] ST_PREHEAT = 3'd2;
   localparam logic [2:0] ST_EXTRUDE = 3'd3;
   localparam logic [2:0] ST_COOL    = 3'd4;
   localparam logic [2:0] ST_FAULT   = 3'd5;
   localparam logic [2:0] ST_ESTOP   = 3'd6;
   localparam logic [2:0] ST_NONE    = 3'd7;

   // Material codes.
   localparam logic [1:0] MAT_NONE = 2'd0;
   localparam logic [1:0] MAT_PLA  = 2'd1;
   localparam logic [1:0] MAT_PET  = 2'd2;

   // Changeover session codes.
   localparam logic [2:0] SES_NONE  = 3'd0;
   localparam logic [2:0] SES_PLA   = 3'd1;
   localparam logic [2:0] SES_PET   = 3'd2;
   localparam logic [2:0] SES_PURGE = 3'd3;
   localparam logic [2:0] SES_FINAL = 3'd7;

   // Safety flag bit positions.
   localparam int SF_ESTOP   = 0;
   localparam int SF_TEMPS   = 5;
   localparam int SF_GAUGE   = 6;
   localparam int SF_HEATFB  = 7;
   localparam int SF_RESTART = 8;
   localparam logic [4:0] SF_GUARDS_ALL = 5'b11111;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FEEDER   = 2'd0;
   localparam logic [1:0] CSR_SCREW    = 2'd1;
   localparam logic [1:0] CSR_SHREDDER = 2'd2;
   localparam logic [1:0] CSR_HEATER   = 2'd3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int MASK_W     = 7;

   typedef struct packed {
      logic [2:0] req_type;
      logic [1:0] requested_material;
      logic [2:0] requested_state;
      logic [2:0] expected_session;
      logic       confirm;
      logic       lockout;
      logic [8:0] safety_flags;
   } req_word_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] machine_state;
      logic [1:0] active_material;
      logic [1:0] pending_material;
      logic [2:0] material_session;
      logic       material_ready;
      logic [3:0] permission_flags;
   } rsp_word_type;

   typedef struct packed {
      logic [MASK_W-1:0] feeder;
      logic [MASK_W-1:0] screw;
      logic [MASK_W-1:0] shredder;
      logic [MASK_W-1:0] heater;
   } cfg_masks_type;

   // Allowed next states for a current state, one bit per target state.
   function automatic logic [7:0] graph_row(input logic [2:0] cur);
      logic [7:0] row;
      unique case (cur)
         ST_IDLE:    row = 8'b0110_0110;
         ST_SHRED:   row = 8'b0110_0101;
         ST_PREHEAT: row = 8'b0111_1000;
         ST_EXTRUDE: row = 8'b0111_0000;
         ST_COOL:    row = 8'b0110_0001;
         ST_FAULT:   row = 8'b0100_0001;
         ST_ESTOP:   row = 8'b0000_0001;
         default:    row = 8'b0000_0000;
      endcase
      return row;
   endfunction

   // Permission bits of a machine state; the unused code has none.
   function automatic logic [3:0] perm_bits(input cfg_masks_type m, input logic [2:0] st);
      logic [3:0] p;
      p = 4'b0000;
      if (st != ST_NONE) begin
         p = {m.heater[st], m.shredder[st], m.screw[st], m.feeder[st]};
      end
      return p;
   endfunction

   // Material is set and its own active session is current.
   function automatic logic mat_ready(input logic [1:0] mat, input logic [2:0] ses);
      return ((mat == MAT_PLA) && (ses == SES_PLA)) ||
             ((mat == MAT_PET) && (ses == SES_PET));
   endfunction

endpackage

/* rtl/pis_csr.sv */
// ----------------------------------------------------------------------------
// Process interlock sequencer configuration registers
// APB-style register file holding the four per-state permission masks.
// ----------------------------------------------------------------------------
module pis_csr import pis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_masks_type         masks
);

   cfg_masks_type masks_ff;
   cfg_masks_type masks_in;
   logic [1:0]    reg_index;
   logic          wr_en;
   logic [MASK_W-1:0] rd_mask;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Write decode.
   always_comb begin
      masks_in = masks_ff;
      if (wr_en) begin
         unique case (reg_index)
            CSR_FEEDER:   masks_in.feeder   = pwdata[MASK_W-1:0];
            CSR_SCREW:    masks_in.screw    = pwdata[MASK_W-1:0];
            CSR_SHREDDER: masks_in.shredder = pwdata[MASK_W-1:0];
            CSR_HEATER:   masks_in.heater   = pwdata[MASK_W-1:0];
            default:      masks_in = masks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff <= '0;
      end else begin
         masks_ff <= masks_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_index)
         CSR_FEEDER:   rd_mask = masks_ff.feeder;
         CSR_SCREW:    rd_mask = masks_ff.screw;
         CSR_SHREDDER: rd_mask = masks_ff.shredder;
         CSR_HEATER:   rd_mask = masks_ff.heater;
         default:      rd_mask = '0;
      endcase
   end

   assign prdata = {{(CSR_DATA_W-MASK_W){1'b0}}, rd_mask};
   assign masks  = masks_ff;

endmodule

/* rtl/pis_core.sv */
// ----------------------------------------------------------------------------
// Process interlock sequencer core
// Holds the machine state, material, pending material and changeover session,
// and evaluates one command word against them in a single pass.
// ----------------------------------------------------------------------------
module pis_core import pis_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  req_word_type  cmd,
   input  cfg_masks_type masks,
   output rsp_word_type  result
);

   logic [2:0] state_ff, state_in;
   logic [1:0] mat_ff, mat_in;
   logic [1:0] pend_ff, pend_in;
   logic [2:0] ses_ff, ses_in;
   logic       ok;
   logic       guards_ok;
   logic       mat_valid;
   logic       running;
   logic       in_halt;
   logic [3:0] new_perm;
   logic [3:0] cur_perm;
   logic [7:0] cur_row;
   logic [1:0] sel_mat;

   assign guards_ok = (cmd.safety_flags[4:0] == SF_GUARDS_ALL);
   assign mat_valid = (cmd.requested_material == MAT_PLA) ||
                      (cmd.requested_material == MAT_PET);
   assign running   = (cmd.requested_state == ST_SHRED) ||
                      (cmd.requested_state == ST_PREHEAT) ||
                      (cmd.requested_state == ST_EXTRUDE);
   assign in_halt   = (state_ff == ST_FAULT) || (state_ff == ST_ESTOP);
   assign new_perm  = perm_bits(masks, cmd.requested_state);
   assign cur_perm  = perm_bits(masks, state_ff);
   assign cur_row   = graph_row(state_ff);
   assign sel_mat   = (ses_ff == SES_FINAL) ? pend_ff : mat_ff;

   // Command evaluation.
   always_comb begin
      state_in = state_ff;
      mat_in   = mat_ff;
      pend_in  = pend_ff;
      ses_in   = ses_ff;
      ok       = 1'b0;
      unique case (cmd.req_type)
         REQ_SELECT_MAT: begin
            if ((state_ff == ST_IDLE) && mat_valid &&
                ((mat_ff == MAT_NONE) || (mat_ff == cmd.requested_material))) begin
               mat_in  = cmd.requested_material;
               pend_in = MAT_NONE;
               ses_in  = (cmd.requested_material == MAT_PLA) ? SES_PLA : SES_PET;
               ok      = 1'b1;
            end
         end
         REQ_CHANGE_MAT: begin
            if ((state_ff == ST_IDLE) && guards_ok && mat_valid && (mat_ff != MAT_NONE) &&
                (cmd.requested_material != mat_ff) &&
                (cur_perm[1:0] == 2'b00)) begin
               pend_in = cmd.requested_material;
               ses_in  = SES_PURGE;
               ok      = 1'b1;
            end
         end
         REQ_ACK_STEP: begin
            if ((state_ff == ST_IDLE) && (ses_ff == cmd.expected_session) && cmd.confirm &&
                (ses_ff >= SES_PURGE)) begin
               if (ses_ff == SES_FINAL) begin
                  // Final confirm activates the pending material.
                  mat_in  = sel_mat;
                  pend_in = MAT_NONE;
                  ses_in  = (sel_mat == MAT_PLA) ? SES_PLA : SES_PET;
               end else begin
                  ses_in = ses_ff + 3'd1;
               end
               ok = 1'b1;
            end
         end
         REQ_SET_STATE: begin
            // Guard chain for a state request; a lost estop wins over all.
            priority if (!cmd.safety_flags[SF_ESTOP]) begin
               state_in = ST_ESTOP;
               ok       = (cmd.requested_state == ST_ESTOP);
            end else if (!cur_row[cmd.requested_state] || (mat_ff == MAT_NONE)) begin
               ok = 1'b0;
            end else if (running && (!mat_ready(mat_ff, ses_ff) || !guards_ok)) begin
               ok = 1'b0;
            end else if ((cmd.requested_state == ST_EXTRUDE) &&
                         (!cmd.safety_flags[SF_TEMPS] || !cmd.safety_flags[SF_GAUGE] ||
                          !cmd.safety_flags[SF_HEATFB])) begin
               ok = 1'b0;
            end else if (in_halt && (cmd.requested_state == ST_IDLE) &&
                         !cmd.safety_flags[SF_RESTART]) begin
               ok = 1'b0;
            end else begin
               state_in = cmd.requested_state;
               ok       = !(new_perm[2] && (new_perm[1] || new_perm[3]));
            end
         end
         REQ_FAULT: begin
            state_in = ST_FAULT;
            ok       = 1'b1;
         end
         REQ_CLEAR_FAULT: begin
            if (in_halt && cmd.lockout && guards_ok && cmd.safety_flags[SF_RESTART]) begin
               state_in = ST_IDLE;
               ok       = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Sequencer state registers, updated once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mat_ff   <= MAT_NONE;
         pend_ff  <= MAT_NONE;
         ses_ff   <= SES_NONE;
      end else if (fire) begin
         state_ff <= state_in;
         mat_ff   <= mat_in;
         pend_ff  <= pend_in;
         ses_ff   <= ses_in;
      end
   end

   // Result reflects the registers after this command.
   always_comb begin
      result.accepted         = ok;
      result.machine_state    = state_in;
      result.active_material  = mat_in;
      result.pending_material = pend_in;
      result.material_session = ses_in;
      result.material_ready   = mat_ready(mat_in, ses_in);
      result.permission_flags = perm_bits(masks, state_in);
   end

endmodule

/* rtl/process_interlock_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Process interlock sequencer
// Safety-interlocked machine and material changeover sequencer with an input
// register, a single-pass evaluation core and a result register.
// ----------------------------------------------------------------------------
// Flow: a taken word is held in the input register and evaluated by the core,
// and its result word is registered in the result register, raising rsp_valid,
// once that register is free or draining.
// Throughput: one word per cycle; a stalled result register holds the input.
// Reset: synchronous, active high; clears both valid flags, the sequencer
// state (idle, no material, no session) and all permission masks.
module process_interlock_sequencer_unit import pis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   req_word_type  req_word_ff, req_word_in;
   logic          req_valid_ff, req_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  core_result;
   cfg_masks_type masks;
   logic          advance;
   logic          take;

   // A held word moves on when the result register is free or draining.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign take      = req_valid && req_ready;

   pis_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .masks   (masks)
   );

   pis_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .cmd    (req_word_ff),
      .masks  (masks),
      .result (core_result)
   );

   // Input register next values.
   always_comb begin
      req_word_in  = take ? req_word : req_word_ff;
      req_valid_in = take || (req_valid_ff && !advance);
   end

   // Result register next values.
   always_comb begin
      rsp_word_in  = advance ? core_result : rsp_word_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_word_ff <= req_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/pis_checker.sv */
// ----------------------------------------------------------------------------
// Process interlock sequencer port checker
// Watches the top level's ports for result and register port consistency.
// ----------------------------------------------------------------------------
module pis_checker import pis_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_word_type          req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_word_type          rsp_word,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   input logic [CSR_DATA_W-1:0] prdata,
   input logic                  pready
);

   // A stalled result word holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
      else $error("result word changed while stalled");

   // No result is offered in the cycle right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // The material ready flag agrees with the reported material and session.
   a_ready_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.material_ready ==
         (((rsp_word.active_material == MAT_PLA) && (rsp_word.material_session == SES_PLA)) ||
          ((rsp_word.active_material == MAT_PET) && (rsp_word.material_session == SES_PET)))))
      else $error("material ready flag inconsistent");

   // The machine never reports the unused state code.
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.machine_state != ST_NONE))
      else $error("unused machine state reported");

   // A register written with a mask reads back that mask on the next cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready) |=>
         (!($past(paddr) == paddr) || (prdata[MASK_W-1:0] == $past(pwdata[MASK_W-1:0]))))
      else $error("register read back differs from written value");

endmodule

bind process_interlock_sequencer_unit pis_checker u_pis_checker (.*);
